### src/pmpu_pkg.sv
// Shared types and codes for the paged memory protection unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package pmpu_pkg;

   // Request function codes.
   localparam logic [2:0] FUNC_READ    = 3'd0;
   localparam logic [2:0] FUNC_WRITE   = 3'd1;
   localparam logic [2:0] FUNC_MAP     = 3'd2;
   localparam logic [2:0] FUNC_UNMAP   = 3'd3;
   localparam logic [2:0] FUNC_PROTECT = 3'd4;

   // Response status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
   localparam logic [1:0] STATUS_NO_PERM  = 2'd2;

   // Permission bits.
   localparam logic [2:0] PERM_R = 3'b001;
   localparam logic [2:0] PERM_W = 3'b010;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic range_init;
      logic byte_commit;
      logic page_chk;
      logic page_upd;
      logic page_next;
      logic zero_start;
      logic zero_step;
      logic clr_step;
   } pmpu_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] func;
      logic       byte_fault;
      logic       byte_last;
      logic       range_empty;
      logic       page_absent;
      logic       page_last;
      logic       zero_last;
      logic       clr_last;
   } pmpu_stat_type;

endpackage
`default_nettype wire

### src/paged_memory_with_page_protection_unit.sv
// Paged memory with page-granular protection: top level.
// The request channel (req_) carries one word per operation: read, write, map,
// unmap or protect. The response channel (rsp_) returns one word per request
// with a status, the read data and the faulting address.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. The block works on one request at a time and holds req_stall high
// from acceptance until its response word has been taken.
// A read or write checks its bytes one at a time, up to 8 bytes, and fewer
// when a byte faults. Range operations walk their pages one at a time, and a
// map zero-fills each absent page that it walks. An unused function code goes
// straight to its response.
// After reset the page table is cleared by a pass over all 2^(ADDR_BITS-PAGE_BITS)
// entries (256 at the default sizes) while req_stall stays high.
// When the receiver stalls, the response word holds steady and no new request
// is taken until it leaves.
// Depends on pmpu_pkg, pmpu_ctrl, pmpu_dp and pmpu_ram.
`default_nettype none
module paged_memory_with_page_protection_unit #(
   parameter int PAGE_BITS = 12,
   parameter int ADDR_BITS = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [2:0]           req_func,
   input  wire logic [ADDR_BITS-1:0] req_addr,
   input  wire logic [1:0]           req_access_size_log,
   input  wire logic [20:0]          req_range_length,
   input  wire logic [63:0]          req_write_data,
   input  wire logic [2:0]           req_new_prot,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [63:0]               rsp_read_data,
   output logic [ADDR_BITS-1:0]      rsp_fault_addr
);
   import pmpu_pkg::*;

   // Commands and status join the controller and the datapath.
   pmpu_cmd_type  cmd;
   pmpu_stat_type stat;

   // The controller sequences byte checks, page walks, zero fill and the
   // reset clearing pass; it also owns both handshakes.
   pmpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the request word, counters, the page table and the
   // byte store, and registers the response word.
   pmpu_dp #(.PAGE_BITS(PAGE_BITS), .ADDR_BITS(ADDR_BITS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_func            (req_func),
      .req_addr            (req_addr),
      .req_access_size_log (req_access_size_log),
      .req_range_length    (req_range_length),
      .req_write_data      (req_write_data),
      .req_new_prot        (req_new_prot),
      .rsp_status          (rsp_status),
      .rsp_read_data       (rsp_read_data),
      .rsp_fault_addr      (rsp_fault_addr)
   );
endmodule
`default_nettype wire

### src/pmpu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the page table and the byte store.
`default_nettype none
module pmpu_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [0:(64'd1 << ADDR_W) - 64'd1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### src/pmpu_ctrl.sv
// Controller state machine of the paged memory protection unit.
// Depends on pmpu_pkg; drives the datapath by command and reads its status.
`default_nettype none
module pmpu_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pmpu_pkg::pmpu_cmd_type      cmd,
   input  wire pmpu_pkg::pmpu_stat_type stat
);
   import pmpu_pkg::*;

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DEC   = 4'd2;
   localparam logic [3:0] ST_BCHK  = 4'd3;
   localparam logic [3:0] ST_BEVAL = 4'd4;
   localparam logic [3:0] ST_RTEST = 4'd5;
   localparam logic [3:0] ST_PCHK  = 4'd6;
   localparam logic [3:0] ST_PEVAL = 4'd7;
   localparam logic [3:0] ST_ZERO  = 4'd8;
   localparam logic [3:0] ST_RESP  = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            cmd.range_init = 1'b1;
            case (stat.func) inside
               FUNC_READ, FUNC_WRITE:            state_in = ST_BCHK;
               FUNC_MAP, FUNC_UNMAP, FUNC_PROTECT: state_in = ST_RTEST;
               default:                          state_in = ST_RESP;
            endcase
         end
         ST_BCHK: begin
            state_in = ST_BEVAL;
         end
         ST_BEVAL: begin
            cmd.byte_commit = 1'b1;
            if (stat.byte_fault || stat.byte_last) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_BCHK;
            end
         end
         ST_RTEST: begin
            state_in = stat.range_empty ? ST_RESP : ST_PCHK;
         end
         ST_PCHK: begin
            cmd.page_chk = 1'b1;
            state_in = ST_PEVAL;
         end
         ST_PEVAL: begin
            cmd.page_upd = 1'b1;
            if (stat.func == FUNC_MAP && stat.page_absent) begin
               cmd.zero_start = 1'b1;
               state_in = ST_ZERO;
            end else begin
               cmd.page_next = 1'b1;
               state_in = stat.page_last ? ST_RESP : ST_PCHK;
            end
         end
         ST_ZERO: begin
            cmd.zero_step = 1'b1;
            if (stat.zero_last) begin
               cmd.page_next = 1'b1;
               state_in = stat.page_last ? ST_RESP : ST_PCHK;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### src/pmpu_dp.sv
// Datapath of the paged memory protection unit: request registers, counters,
// page table and byte store. Depends on pmpu_pkg and pmpu_ram.
`default_nettype none
module pmpu_dp #(
   parameter int PAGE_BITS = 12,
   parameter int ADDR_BITS = 20
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pmpu_pkg::pmpu_cmd_type cmd,
   output pmpu_pkg::pmpu_stat_type     stat,
   input  wire logic [2:0]             req_func,
   input  wire logic [ADDR_BITS-1:0]   req_addr,
   input  wire logic [1:0]             req_access_size_log,
   input  wire logic [20:0]            req_range_length,
   input  wire logic [63:0]            req_write_data,
   input  wire logic [2:0]             req_new_prot,
   output logic [1:0]                  rsp_status,
   output logic [63:0]                 rsp_read_data,
   output logic [ADDR_BITS-1:0]        rsp_fault_addr
);
   import pmpu_pkg::*;

   localparam int EFF_PB    = (PAGE_BITS < ADDR_BITS) ? PAGE_BITS : ADDR_BITS;
   localparam int PIDX_W    = (ADDR_BITS - EFF_PB > 0) ? ADDR_BITS - EFF_PB : 1;
   localparam int NUM_PAGES = 1 << (ADDR_BITS - EFF_PB);
   localparam int EW        = ((ADDR_BITS > 21) ? ADDR_BITS : 21) + 2;
   localparam int PG_MASK   = (1 << EFF_PB) - 1;

   logic [2:0]           func_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [1:0]           size_ff;
   logic [20:0]          len_ff;
   logic [63:0]          wdata_ff;
   logic [2:0]           prot_ff;
   logic [2:0]           idx_ff;
   logic [PIDX_W:0]      p_ff;
   logic [PIDX_W:0]      last_ff;
   logic [EFF_PB-1:0]    z_ff;
   logic [63:0]          rdata_ff;
   logic [1:0]           status_ff;
   logic [ADDR_BITS-1:0] faddr_ff;

   logic [ADDR_BITS-1:0] byte_addr;
   logic [PIDX_W-1:0]    byte_page;
   logic [PIDX_W-1:0]    pt_rd_addr;
   logic [3:0]           pt_rd_data;
   logic                 pt_wr_en;
   logic [3:0]           pt_wr_data;
   logic [7:0]           mem_rd_data;
   logic                 mem_wr_en;
   logic [ADDR_BITS-1:0] mem_wr_addr;
   logic [7:0]           mem_wr_data;
   logic [ADDR_BITS-1:0] zero_addr;
   logic [2:0]           need;
   logic [1:0]           fault_code;
   logic [2:0]           last_idx;
   logic [PIDX_W:0]      first_page;
   logic [EW-1:0]        end_sum;
   logic [EW-1:0]        end_sat;
   logic [EW-1:0]        end_rnd;

   assign byte_addr  = addr_ff + ADDR_BITS'(idx_ff);
   assign byte_page  = PIDX_W'(byte_addr >> EFF_PB);
   assign pt_rd_addr = cmd.page_chk ? p_ff[PIDX_W-1:0] : byte_page;
   assign zero_addr  = ADDR_BITS'(((ADDR_BITS + PIDX_W)'(p_ff[PIDX_W-1:0]) << EFF_PB)
                                  | (ADDR_BITS + PIDX_W)'(z_ff));
   assign last_idx   = 3'((4'd1 << size_ff) - 4'd1);

   // Page permission check for the current byte.
   assign need = (func_ff == FUNC_READ) ? PERM_R : PERM_W;
   always_comb begin
      if (!pt_rd_data[3]) begin
         fault_code = STATUS_UNMAPPED;
      end else if ((pt_rd_data[2:0] & need) != need) begin
         fault_code = STATUS_NO_PERM;
      end else begin
         fault_code = STATUS_OK;
      end
   end

   // Range bounds: end saturates at the top of the space, then rounds up.
   assign first_page = (PIDX_W + 1)'(addr_ff >> EFF_PB);
   assign end_sum    = EW'(addr_ff) + EW'(len_ff);
   assign end_sat    = (end_sum > (EW'(1) << ADDR_BITS)) ? (EW'(1) << ADDR_BITS) : end_sum;
   assign end_rnd    = (end_sat + EW'(PG_MASK)) >> EFF_PB;

   // Page table writes.
   always_comb begin
      pt_wr_en   = 1'b0;
      pt_wr_data = 4'd0;
      if (cmd.clr_step) begin
         pt_wr_en = 1'b1;
      end else if (cmd.page_upd) begin
         case (func_ff)
            FUNC_MAP: begin
               pt_wr_en   = 1'b1;
               pt_wr_data = {1'b1, prot_ff};
            end
            FUNC_PROTECT: begin
               pt_wr_en   = pt_rd_data[3];
               pt_wr_data = {1'b1, prot_ff};
            end
            default: begin
               pt_wr_en = 1'b1;
            end
         endcase
      end
   end

   // Byte store writes: a stored write byte or a zero-fill byte.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = byte_addr;
      mem_wr_data = wdata_ff[{idx_ff, 3'b000} +: 8];
      if (cmd.zero_step) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = zero_addr;
         mem_wr_data = 8'd0;
      end else if (cmd.byte_commit && func_ff == FUNC_WRITE && fault_code == STATUS_OK) begin
         mem_wr_en = 1'b1;
      end
   end

   pmpu_ram #(.WIDTH(4), .ADDR_W(PIDX_W)) u_page_ram (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (p_ff[PIDX_W-1:0]),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   pmpu_ram #(.WIDTH(8), .ADDR_W(ADDR_BITS)) u_byte_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (byte_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= '0;
      end else if (cmd.range_init) begin
         p_ff <= first_page;
      end else if (cmd.page_next || cmd.clr_step) begin
         p_ff <= p_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         addr_ff   <= req_addr;
         size_ff   <= req_access_size_log;
         len_ff    <= req_range_length;
         wdata_ff  <= req_write_data;
         prot_ff   <= req_new_prot;
         idx_ff    <= 3'd0;
         rdata_ff  <= 64'd0;
         status_ff <= STATUS_OK;
         faddr_ff  <= '0;
      end else if (cmd.byte_commit) begin
         if (fault_code != STATUS_OK) begin
            status_ff <= fault_code;
            faddr_ff  <= byte_addr;
         end else begin
            if (func_ff == FUNC_READ) begin
               rdata_ff[{idx_ff, 3'b000} +: 8] <= mem_rd_data;
            end
            idx_ff <= idx_ff + 3'd1;
         end
      end
      if (cmd.range_init) begin
         last_ff <= (PIDX_W + 1)'(end_rnd);
      end
      if (cmd.zero_start) begin
         z_ff <= '0;
      end else if (cmd.zero_step) begin
         z_ff <= z_ff + 1'b1;
      end
   end

   assign stat.func        = func_ff;
   assign stat.byte_fault  = fault_code != STATUS_OK;
   assign stat.byte_last   = idx_ff == last_idx;
   assign stat.range_empty = (p_ff >= last_ff) || (func_ff == FUNC_MAP && len_ff == 21'd0);
   assign stat.page_absent = !pt_rd_data[3];
   assign stat.page_last   = (p_ff + 1'b1) == last_ff;
   assign stat.zero_last   = &z_ff;
   assign stat.clr_last    = p_ff == (PIDX_W + 1)'(NUM_PAGES - 1);

   assign rsp_status     = status_ff;
   assign rsp_read_data  = (status_ff == STATUS_OK && func_ff == FUNC_READ) ? rdata_ff : 64'd0;
   assign rsp_fault_addr = faddr_ff;
endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for paged_memory_with_page_protection_unit.
// Runs directed and random read, write, map, unmap and protect words and checks every
// response against an in-bench page table and byte store. Depends on pmpu_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import pmpu_pkg::*;

   localparam int PG_BITS = 12;
   localparam int AD_BITS = 20;
   localparam longint unsigned SPACE = 64'd1 << AD_BITS;
   localparam longint unsigned PG_MASK = (64'd1 << PG_BITS) - 1;
   localparam int N_PAGES = 1 << (AD_BITS - PG_BITS);
   localparam longint unsigned CYCLE_LIMIT = 6000000;
   localparam logic [2:0] FUNC_SPARE = 3'd5;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [2:0]          req_func;
   logic [AD_BITS-1:0]  req_addr;
   logic [1:0]          req_access_size_log;
   logic [20:0]         req_range_length;
   logic [63:0]         req_write_data;
   logic [2:0]          req_new_prot;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_status;
   logic [63:0]         rsp_read_data;
   logic [AD_BITS-1:0]  rsp_fault_addr;

   // One expected response word.
   typedef struct {
      logic [1:0]         status;
      logic [63:0]        read_data;
      logic [AD_BITS-1:0] fault_addr;
   } access_result_type;

   // Shadow copy of the page table and the byte store.
   logic       shadow_present [N_PAGES];
   logic [2:0] shadow_perm [N_PAGES];
   logic [7:0] shadow_bytes [SPACE];

   access_result_type pending_results[$];
   int  send_idle_pct;
   int  recv_idle_pct;
   int  mismatches;
   int  words_sent;
   int  words_checked;
   int  zero_fills;
   longint unsigned cycles;

   paged_memory_with_page_protection_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_addr(req_addr), .req_access_size_log(req_access_size_log),
      .req_range_length(req_range_length), .req_write_data(req_write_data),
      .req_new_prot(req_new_prot),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_read_data(rsp_read_data), .rsp_fault_addr(rsp_fault_addr)
   );

   // 20 ns clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog: the run must end well before this many cycles.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Checks the status of one page for a single byte address.
   function automatic logic [1:0] page_check(input longint unsigned a, input logic [2:0] need);
      int pg;
      pg = int'((a & (SPACE - 1)) >> PG_BITS);
      if (!shadow_present[pg]) return STATUS_UNMAPPED;
      if ((shadow_perm[pg] & need) != need) return STATUS_NO_PERM;
      return STATUS_OK;
   endfunction

   // Applies one request word to the shadow state and returns the response it
   // must produce. A range is rounded out to pages, and its end saturates at
   // the top of the space before rounding.
   function automatic access_result_type apply_request(input logic [2:0] f,
         input logic [AD_BITS-1:0] a, input logic [1:0] size_log,
         input logic [20:0] len, input logic [63:0] wdata, input logic [2:0] prot);
      access_result_type res;
      longint unsigned start, stop, b;
      int nbytes, first, last;
      logic [2:0] need;
      res.status = STATUS_OK;
      res.read_data = '0;
      res.fault_addr = '0;
      nbytes = 1 << size_log;
      if (f == FUNC_READ || f == FUNC_WRITE) begin
         need = (f == FUNC_READ) ? PERM_R : PERM_W;
         if ((a & PG_MASK) + nbytes <= PG_MASK + 1) begin
            res.status = page_check(a, need);
            if (res.status != STATUS_OK) begin
               res.fault_addr = a;
            end else begin
               for (int i = 0; i < nbytes; i++) begin
                  if (f == FUNC_READ) res.read_data[8*i +: 8] = shadow_bytes[a + i];
                  else shadow_bytes[a + i] = wdata[8*i +: 8];
               end
            end
         end else begin
            // Page-crossing access: byte by byte, stopping at the first fault,
            // so a write may leave its lower bytes stored.
            for (int i = 0; i < nbytes; i++) begin
               b = (a + i) & (SPACE - 1);
               res.status = page_check(b, need);
               if (res.status != STATUS_OK) begin
                  res.fault_addr = AD_BITS'(b);
                  break;
               end
               if (f == FUNC_READ) res.read_data[8*i +: 8] = shadow_bytes[b];
               else shadow_bytes[b] = wdata[8*i +: 8];
            end
         end
         if (res.status != STATUS_OK || f != FUNC_READ) res.read_data = '0;
      end else if (f == FUNC_MAP || f == FUNC_UNMAP || f == FUNC_PROTECT) begin
         start = a & ~PG_MASK;
         stop = a + len;
         if (stop > SPACE) stop = SPACE;
         stop = (stop + PG_MASK) & ~PG_MASK;
         first = int'(start >> PG_BITS);
         last = int'(stop >> PG_BITS);
         // A map of length zero does nothing at all.
         if (f == FUNC_MAP && len == 0) last = first;
         for (int p = first; p < last; p++) begin
            if (f == FUNC_MAP) begin
               if (!shadow_present[p]) begin
                  for (int k = 0; k <= PG_MASK; k++) shadow_bytes[(p << PG_BITS) + k] = 8'h00;
                  shadow_present[p] = 1'b1;
                  zero_fills++;
               end
               shadow_perm[p] = prot;
            end else if (f == FUNC_UNMAP) begin
               shadow_present[p] = 1'b0;
               shadow_perm[p] = 3'b000;
            end else if (shadow_present[p]) begin
               shadow_perm[p] = prot;
            end
         end
      end
      return res;
   endfunction

   // Sends one word. Valid stays high from one word to the next unless the
   // sender idles, so it is never lowered and raised in the same step.
   task automatic send_word(input logic [2:0] f, input logic [AD_BITS-1:0] a,
         input logic [1:0] size_log, input logic [20:0] len,
         input logic [63:0] wdata, input logic [2:0] prot);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func <= f;
      req_addr <= a;
      req_access_size_log <= size_log;
      req_range_length <= len;
      req_write_data <= wdata;
      req_new_prot <= prot;
      req_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pending_results.insert(pending_results.size(),
                             apply_request(f, a, size_log, len, wdata, prot));
      words_sent++;
      @(negedge clock);
   endtask

   // Holds the sender off until every expected response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Compares each accepted response word with the oldest expectation.
   always @(posedge clock) begin
      access_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response word: status %0d", rsp_status);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            words_checked++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
               mismatches++;
            end
            if (rsp_fault_addr !== want.fault_addr) begin
               $error("fault_addr: expected %h, got %h", want.fault_addr, rsp_fault_addr);
               mismatches++;
            end
         end
      end
   end

   // Accesses before anything is mapped, and the empty and reserved cases.
   task automatic test_empty_space();
      send_word(FUNC_READ, 20'h00000, 2'd3, 21'd0, 64'd0, 3'd0);
      send_word(FUNC_MAP, 20'h00000, 2'd0, 21'd0, 64'd0, 3'd7);
      send_word(FUNC_READ, 20'h00000, 2'd0, 21'd0, 64'd0, 3'd0);
      for (int f = FUNC_SPARE; f <= 7; f++)
         send_word(3'(f), 20'hFFFFF, 2'd3, 21'h1FFFFF, '1, 3'd7);
   endtask

   // Mapping, crossing accesses, partial writes and protection changes.
   task automatic test_map_protect();
      send_word(FUNC_MAP, 20'h00010, 2'd0, 21'h2000, 64'd0, 3'd7);
      send_word(FUNC_WRITE, 20'h00FFC, 2'd3, 21'd0, 64'h8877_6655_4433_2211, 3'd0);
      send_word(FUNC_READ, 20'h00FFC, 2'd3, 21'd0, 64'd0, 3'd0);
      send_word(FUNC_PROTECT, 20'h01000, 2'd0, 21'd0, 64'd0, 3'd1);
      send_word(FUNC_PROTECT, 20'h01001, 2'd0, 21'd0, 64'd0, 3'd1);
      send_word(FUNC_WRITE, 20'h00FFE, 2'd2, 21'd0, 64'hDEAD_BEEF, 3'd0);
      send_word(FUNC_READ, 20'h00FFC, 2'd3, 21'd0, 64'd0, 3'd0);
      send_word(FUNC_WRITE, 20'h01000, 2'd0, 21'd0, 64'hFF, 3'd0);
      send_word(FUNC_PROTECT, 20'h05000, 2'd0, 21'h1000, 64'd0, 3'd7);
      send_word(FUNC_READ, 20'h05000, 2'd1, 21'd0, 64'd0, 3'd0);
      // Remapping a present page keeps its data and only changes its rights.
      send_word(FUNC_MAP, 20'h02000, 2'd0, 21'd1, 64'd0, 3'd0);
      send_word(FUNC_READ, 20'h02000, 2'd0, 21'd0, 64'd0, 3'd0);
   endtask

   // Top of the space: saturating range end, wraparound, full-length ranges.
   task automatic test_space_edges();
      send_word(FUNC_MAP, 20'hFF800, 2'd0, 21'h100000, 64'd0, 3'd3);
      send_word(FUNC_WRITE, 20'hFFFFC, 2'd3, 21'd0, 64'h0123_4567_89AB_CDEF, 3'd0);
      send_word(FUNC_READ, 20'hFFFFE, 2'd2, 21'd0, 64'd0, 3'd0);
      send_word(FUNC_UNMAP, 20'h01800, 2'd0, 21'h800, 64'd0, 3'd0);
      send_word(FUNC_READ, 20'h00FFF, 2'd1, 21'd0, 64'd0, 3'd0);
      send_word(FUNC_UNMAP, 20'h00000, 2'd0, 21'h100000, 64'd0, 3'd0);
      send_word(FUNC_WRITE, 20'hFFFFF, 2'd3, 21'd0, '1, 3'd7);
   endtask

   // Random words on a small working set of pages at both ends of the space,
   // with offsets biased toward page ends so that many accesses cross pages.
   task automatic test_random(input int count);
      int r, pg;
      logic [AD_BITS-1:0] a;
      logic [20:0] len;
      logic [2:0] f;
      for (int n = 0; n < count; n++) begin
         pg = $urandom_range(0, 15);
         if (pg >= 8) pg = N_PAGES - 16 + pg;
         a = AD_BITS'(pg << PG_BITS);
         if ($urandom_range(0, 1)) a = AD_BITS'(a + (PG_MASK + 1 - $urandom_range(1, 8)));
         else a = AD_BITS'(a + $urandom_range(0, PG_MASK));
         len = 21'($urandom_range(0, 8192));
         r = $urandom_range(0, 99);
         if (r < 40) f = FUNC_READ;
         else if (r < 80) f = FUNC_WRITE;
         else if (r < 88) f = FUNC_PROTECT;
         else if (r < 93) f = FUNC_MAP;
         else if (r < 97) f = FUNC_UNMAP;
         else f = 3'($urandom_range(FUNC_SPARE, 7));
         // Long ranges only where they stay cheap: a map at the top page
         // saturates, and unmap or protect walk without zero-filling.
         if ((f == FUNC_MAP && pg == N_PAGES - 1) || (f != FUNC_MAP && $urandom_range(0, 9) == 0))
            len = 21'($urandom_range(0, 21'h100000)) | 21'($urandom_range(0, 1) << 20);
         if (len > 21'h100000) len = 21'h100000;
         send_word(f, a, 2'($urandom_range(0, 3)), len,
                   {$urandom(), $urandom()}, 3'($urandom_range(0, 7)));
         if (n % 300 == 299) drain_responses();
      end
   endtask

   initial begin
      cycles = 0;
      mismatches = 0;
      words_sent = 0;
      words_checked = 0;
      zero_fills = 0;
      send_idle_pct = 17;
      recv_idle_pct = 55;
      for (int p = 0; p < N_PAGES; p++) begin
         shadow_present[p] = 1'b0;
         shadow_perm[p] = 3'b000;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_READ;
      req_addr = '0;
      req_access_size_log = '0;
      req_range_length = '0;
      req_write_data = '0;
      req_new_prot = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_space();
      test_map_protect();
      test_space_edges();
      drain_responses();
      test_random(620);
      send_idle_pct = 55;
      recv_idle_pct = 17;
      test_random(620);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(610);
      drain_responses();
      repeat (40) @(negedge clock);

      $display("Sent %0d words, checked %0d responses, %0d page zero-fills.",
               words_sent, words_checked, zero_fills);
      $display("Covered faults, partial writes, wraparound and range saturation.");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
